// ===== rtl/core/ems_pkg.sv =====
// Shared types and constants for the expiring message store.
`timescale 1ns / 1ps
package ems_pkg;
    localparam int SLOTS = 16;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    localparam logic [31:0] BUDGET_RESET   = 32'd5000000;
    localparam logic [31:0] LIFETIME_RESET = 32'd1000;

    typedef enum logic [2:0] {
        ACT_SAVE   = 3'd0,
        ACT_LOOKUP = 3'd1,
        ACT_DELETE = 3'd2,
        ACT_EXPIRE = 3'd3,
        ACT_LIST   = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        ST_STORED    = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_NO_ROOM   = 3'd2,
        ST_FOUND     = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_DONE      = 3'd5,
        ST_LIST_ITEM = 3'd6,
        ST_LIST_EMPTY = 3'd7
    } t_status;

    localparam logic [1:0] REG_BUDGET   = 2'd0;
    localparam logic [1:0] REG_LIFETIME = 2'd1;
    localparam logic [1:0] REG_HOLD     = 2'd2;

    // one slot record: key, size, hops, expiry, purge time, flag
    typedef struct packed {
        logic [31:0] key;
        logic [15:0] size;
        logic [7:0]  hops;
        logic [31:0] expiry;
        logic [31:0] purge;
        logic        flagged;
    } t_slot;

    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  position;
        logic [31:0] entry_key;
        logic [7:0]  entry_hops;
        logic [31:0] entry_expiry;
        logic [31:0] used_bytes;
        logic [4:0]  entry_count;
        logic        last;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DUP_RD,
        S_EVICT_RD,
        S_EVICT_DEL,
        S_FILTER_RD,
        S_APPEND,
        S_LOOK_RD,
        S_LIST_RD,
        S_RESULT
    } t_state;
endpackage

// ===== rtl/core/ems_slot_ram.sv =====
// Slot memory: one write port, one registered read port.
`timescale 1ns / 1ps
module ems_slot_ram (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [ems_pkg::IDX_W-1:0]  i_waddr,
    input  ems_pkg::t_slot             i_wdata,
    input  logic [ems_pkg::IDX_W-1:0]  i_raddr,
    output ems_pkg::t_slot             o_rdata
);
    import ems_pkg::*;

    t_slot r_mem [SLOTS];
    t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/ems_cfg_regs.sv =====
// APB configuration registers.
`timescale 1ns / 1ps
module ems_cfg_regs (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [31:0] o_budget,
    output logic [31:0] o_lifetime,
    output logic [31:0] o_hold
);
    import ems_pkg::*;

    logic [31:0] r_budget, r_lifetime, r_hold;
    logic        wr;
    logic [1:0]  idx;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;
    assign idx    = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget   <= BUDGET_RESET;
            r_lifetime <= LIFETIME_RESET;
            r_hold     <= '0;
        end else if (wr && paddr[1:0] == 2'b00) begin
            case (idx)
                REG_BUDGET:   r_budget   <= pwdata;
                REG_LIFETIME: r_lifetime <= pwdata;
                REG_HOLD:     r_hold     <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_BUDGET:   prdata = r_budget;
            REG_LIFETIME: prdata = r_lifetime;
            REG_HOLD:     prdata = r_hold;
            default:      prdata = '0;
        endcase
    end

    assign o_budget   = r_budget;
    assign o_lifetime = r_lifetime;
    assign o_hold     = r_hold;
endmodule

// ===== rtl/core/ems_ctrl.sv =====
// Action sequencer: scans the slot memory, compacts in place, emits results.
`timescale 1ns / 1ps
module ems_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [2:0]                i_action,
    input  logic [31:0]               i_key,
    input  logic [31:0]               i_now,
    input  logic [15:0]               i_payload_bytes,
    input  logic [7:0]                i_hop_count,
    input  logic                      i_reached_gateway,
    input  logic [7:0]                i_hop_limit,
    input  logic [31:0]               i_budget,
    input  logic [31:0]               i_lifetime,
    input  logic [31:0]               i_hold,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output ems_pkg::t_result          o_result,
    output logic                      o_we,
    output logic [ems_pkg::IDX_W-1:0] o_waddr,
    output ems_pkg::t_slot            o_wdata,
    output logic [ems_pkg::IDX_W-1:0] o_raddr,
    input  ems_pkg::t_slot            i_rdata
);
    import ems_pkg::*;

    t_state r_state, n_state;
    logic [2:0]  r_act;
    logic [31:0] r_key, r_now;
    logic [15:0] r_size;
    logic [7:0]  r_hops, r_limit;
    logic        r_gw;

    logic [CNT_W-1:0] r_count, n_count;
    logic [31:0]      r_bytes, n_bytes;
    // scan pointers: r_rd slot being read (data valid next cycle), r_wr compaction target
    logic [CNT_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_wr, n_wr;
    logic             r_pend, n_pend;     // read data for slot r_rd-1 arrives this cycle
    logic             r_hit, n_hit;
    logic [CNT_W-1:0] r_vic, n_vic;
    logic [31:0]      r_vexp, n_vexp;
    logic             r_has, n_has;

    t_result r_res, n_res;
    t_result r_buf, n_buf;            // list: selected item waiting for its last flag
    logic    r_ovalid, n_ovalid;
    logic    r_done, n_done;          // after result, return to idle

    logic [CNT_W-1:0] cur;
    logic             keep, drop;

    assign cur = r_rd - CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_bytes  <= '0;
            r_ovalid <= 1'b0;
            r_rd <= '0; r_wr <= '0; r_pend <= 1'b0; r_hit <= 1'b0;
            r_vic <= '0; r_vexp <= '0; r_has <= 1'b0; r_done <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_bytes  <= n_bytes;
            r_ovalid <= n_ovalid;
            r_rd <= n_rd; r_wr <= n_wr; r_pend <= n_pend; r_hit <= n_hit;
            r_vic <= n_vic; r_vexp <= n_vexp; r_has <= n_has; r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        r_buf <= n_buf;
        if (i_in_valid && o_in_ready) begin
            r_act <= i_action; r_key <= i_key; r_now <= i_now;
            r_size <= i_payload_bytes; r_hops <= i_hop_count;
            r_gw <= i_reached_gateway; r_limit <= i_hop_limit;
        end
    end

    function automatic t_result mk(input logic [2:0] st, input logic [4:0] pos,
                                   input logic h, input t_slot s,
                                   input logic [31:0] b, input logic [CNT_W-1:0] c,
                                   input logic l);
        t_result r;
        r.status       = st;
        r.position     = pos;
        r.entry_key    = h ? s.key : '0;
        r.entry_hops   = h ? s.hops : '0;
        r.entry_expiry = h ? s.expiry : '0;
        r.used_bytes   = b;
        r.entry_count  = 5'(c);
        r.last         = l;
        return r;
    endfunction

    assign o_in_ready  = (r_state == S_IDLE) && !r_ovalid;
    assign o_out_valid = r_ovalid;
    assign o_result    = r_res;

    always_comb begin
        n_state = r_state; n_count = r_count; n_bytes = r_bytes;
        n_rd = r_rd; n_wr = r_wr; n_pend = 1'b0; n_hit = r_hit;
        n_vic = r_vic; n_vexp = r_vexp; n_has = r_has;
        n_res = r_res; n_buf = r_buf; n_ovalid = r_ovalid; n_done = r_done;
        o_we = 1'b0; o_waddr = r_wr[IDX_W-1:0]; o_wdata = i_rdata;
        o_raddr = r_rd[IDX_W-1:0];
        keep = 1'b1; drop = 1'b0;
        if (r_ovalid && i_out_ready) n_ovalid = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    n_rd = '0; n_wr = '0; n_hit = 1'b0; n_has = 1'b0;
                    case (i_action)
                        ACT_SAVE:   n_state = S_DUP_RD;
                        ACT_LOOKUP, ACT_DELETE, ACT_EXPIRE: n_state = S_FILTER_RD;
                        ACT_LIST:   n_state = S_LIST_RD;
                        default: begin
                            n_res = mk(ST_DONE, '0, 1'b0, i_rdata, r_bytes, r_count, 1'b1);
                            n_ovalid = 1'b1;
                        end
                    endcase
                end
            end
            // duplicate check: read all slots, compare keys
            S_DUP_RD: begin
                if (r_pend && i_rdata.key == r_key) n_hit = 1'b1;
                if (r_rd < r_count) begin
                    n_rd = r_rd + CNT_W'(1); n_pend = 1'b1;
                end else if (!r_pend) begin
                    if (r_hit) begin
                        n_res = mk(ST_DUPLICATE, '0, 1'b0, i_rdata, r_bytes, r_count, 1'b1);
                        n_state = S_RESULT;
                    end else if (i_budget != '0 && r_count != '0 &&
                                 ({1'b0, r_bytes} + 33'(r_size)) > {1'b0, i_budget}) begin
                        n_rd = '0; n_has = 1'b0; n_state = S_EVICT_RD;
                    end else begin
                        n_rd = '0; n_wr = '0; n_state = S_FILTER_RD;
                    end
                end
            end
            // earliest expiry, first one wins on ties
            S_EVICT_RD: begin
                if (r_pend && (!r_has || i_rdata.expiry < r_vexp)) begin
                    n_has = 1'b1; n_vic = cur; n_vexp = i_rdata.expiry;
                end
                if (r_rd < r_count) begin
                    n_rd = r_rd + CNT_W'(1); n_pend = 1'b1;
                end else if (!r_pend) begin
                    n_rd = '0; n_wr = '0; n_state = S_EVICT_DEL;
                end
            end
            // compaction pass dropping only the victim
            S_EVICT_DEL: begin
                if (r_pend) begin
                    if (cur == r_vic) begin
                        n_bytes = r_bytes - 32'(i_rdata.size);
                    end else begin
                        o_we = 1'b1; n_wr = r_wr + CNT_W'(1);
                    end
                end
                if (r_rd < r_count) begin
                    n_rd = r_rd + CNT_W'(1); n_pend = 1'b1;
                end else if (!r_pend) begin
                    n_count = r_count - CNT_W'(1);
                    n_rd = '0; n_wr = '0; n_state = S_FILTER_RD;
                end
            end
            // purge / delete / expire: one compaction pass with a per-action drop test
            S_FILTER_RD: begin
                if (r_pend) begin
                    case (r_act)
                        ACT_EXPIRE: drop = i_rdata.expiry < r_now;
                        ACT_DELETE: drop = (i_rdata.flagged && i_rdata.purge < r_now) ||
                                           i_rdata.key == r_key;
                        default:    drop = i_rdata.flagged && i_rdata.purge < r_now;
                    endcase
                    keep = !drop;
                    if (r_act == ACT_DELETE && i_rdata.key == r_key &&
                        !(i_rdata.flagged && i_rdata.purge < r_now)) n_hit = 1'b1;
                    if (keep) begin
                        o_we = 1'b1; n_wr = r_wr + CNT_W'(1);
                    end else begin
                        n_bytes = r_bytes - 32'(i_rdata.size);
                    end
                end
                if (r_rd < r_count) begin
                    n_rd = r_rd + CNT_W'(1); n_pend = 1'b1;
                end else if (!r_pend) begin
                    n_count = r_wr;
                    case (r_act)
                        ACT_SAVE: n_state = S_APPEND;
                        ACT_LOOKUP: begin
                            n_rd = '0; n_state = S_LOOK_RD;
                        end
                        ACT_DELETE: begin
                            n_res = mk(r_hit ? ST_DONE : ST_NOT_FOUND, '0, 1'b0, i_rdata,
                                       r_bytes, r_wr, 1'b1);
                            n_state = S_RESULT;
                        end
                        default: begin
                            n_res = mk(ST_DONE, '0, 1'b0, i_rdata, r_bytes, r_wr, 1'b1);
                            n_state = S_RESULT;
                        end
                    endcase
                end
            end
            S_APPEND: begin
                if (r_count >= CNT_W'(SLOTS)) begin
                    n_res = mk(ST_NO_ROOM, '0, 1'b0, i_rdata, r_bytes, r_count, 1'b1);
                end else begin
                    o_we = 1'b1;
                    o_waddr = r_count[IDX_W-1:0];
                    o_wdata.key = r_key; o_wdata.size = r_size; o_wdata.hops = r_hops;
                    o_wdata.expiry = r_now + i_lifetime;
                    o_wdata.flagged = r_gw;
                    o_wdata.purge = r_gw ? r_now + i_hold : '0;
                    n_count = r_count + CNT_W'(1);
                    n_bytes = r_bytes + 32'(r_size);
                    n_res = mk(ST_STORED, '0, 1'b0, i_rdata, n_bytes, n_count, 1'b1);
                end
                n_state = S_RESULT;
            end
            S_LOOK_RD: begin
                if (r_pend && i_rdata.key == r_key) begin
                    n_res = mk(ST_FOUND, 5'(r_rd), 1'b1, i_rdata, r_bytes, r_count, 1'b1);
                    n_state = S_RESULT;
                end else if (r_rd < r_count) begin
                    n_rd = r_rd + CNT_W'(1); n_pend = 1'b1;
                end else if (!r_pend) begin
                    n_res = mk(ST_NOT_FOUND, 5'(r_count), 1'b0, i_rdata, r_bytes,
                               r_count, 1'b1);
                    n_state = S_RESULT;
                end
            end
            // list: one read per slot, repeated on a stall; a hit waits in r_buf (r_hit set)
            // until the next hit or the end of the scan, so the final beat can carry last
            S_LIST_RD: begin
                if (r_pend) begin
                    if ({1'b0, i_rdata.hops} + 9'd1 < {1'b0, r_limit}) begin
                        if (r_hit && r_ovalid && !i_out_ready) begin
                            // stall: re-read this slot
                            n_rd = cur;
                        end else begin
                            if (r_hit) begin
                                n_res = r_buf;
                                n_ovalid = 1'b1;
                            end
                            n_buf = mk(ST_LIST_ITEM, 5'(r_rd), 1'b1, i_rdata, r_bytes,
                                       r_count, 1'b0);
                            n_hit = 1'b1;
                        end
                    end
                end else if (r_rd < r_count) begin
                    n_rd = r_rd + CNT_W'(1); n_pend = 1'b1;
                end else if (!r_ovalid || i_out_ready) begin
                    if (r_hit) begin
                        n_res = r_buf;
                        n_res.last = 1'b1;
                    end else begin
                        n_res = mk(ST_LIST_EMPTY, '0, 1'b0, i_rdata, r_bytes, r_count, 1'b1);
                    end
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_RESULT: begin
                n_ovalid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(SLOTS)) else $error("entry count over capacity");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_in_ready) else $error("accept while busy");
    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_we |-> (r_state == S_APPEND || r_wr < r_count)) else $error("write past fill");
    a_empty_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_count == '0) |-> r_bytes == '0)
        else $error("bytes held with no entries");
`endif
endmodule

// ===== rtl/core/expiring_message_store_core.sv =====
// Top level of the expiring message store.
`timescale 1ns / 1ps
// Expiring message store: up to 16 descriptors in insertion order in one
// single-port-read slot memory. Each action is a few sequential passes over the
// held entries, at most one slot read per cycle with compaction written back in
// place (list waits for each read's data and re-reads a slot while the receiver
// stalls): save takes a duplicate pass, an optional eviction search and removal
// pass, a purge pass and an append; lookup takes a purge pass and a search pass;
// delete and expire take one pass each; list one pass. One item is worked at a time.
// No clearing pass is needed after reset.
module expiring_message_store_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // action[2:0], key[34:3], now[66:35], payload_bytes[82:67], hop_count[90:83],
    // reached_gateway[91], hop_limit[99:92], zero fill to 104
    input  logic [103:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[2:0], position[7:3], entry_key[39:8], entry_hops[47:40],
    // entry_expiry[79:48], used_bytes[111:80], entry_count[116:112], zero fill to 120
    output logic [119:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ems_pkg::*;

    logic [31:0] budget, lifetime, hold;
    t_result res;
    logic we;
    logic [IDX_W-1:0] waddr, raddr;
    t_slot wdata, rdata;

    ems_cfg_regs u_cfg (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .o_budget(budget), .o_lifetime(lifetime), .o_hold(hold)
    );

    ems_slot_ram u_ram (
        .i_clk, .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    ems_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .i_action(s_axis_tdata[2:0]), .i_key(s_axis_tdata[34:3]),
        .i_now(s_axis_tdata[66:35]), .i_payload_bytes(s_axis_tdata[82:67]),
        .i_hop_count(s_axis_tdata[90:83]), .i_reached_gateway(s_axis_tdata[91]),
        .i_hop_limit(s_axis_tdata[99:92]),
        .i_budget(budget), .i_lifetime(lifetime), .i_hold(hold),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready), .o_result(res),
        .o_we(we), .o_waddr(waddr), .o_wdata(wdata), .o_raddr(raddr), .i_rdata(rdata)
    );

    assign m_axis_tdata = {3'b000, res.entry_count, res.used_bytes, res.entry_expiry,
                           res.entry_hops, res.entry_key, res.position, res.status};
    assign m_axis_tlast = res.last;
endmodule
